// ----- rtl/stit_pkg.sv -----
// Shared types and constants for the symbol table insert/lookup block.
// No dependencies; used by every module of the block.
package stit_pkg;

    localparam int MaxEntries = 256;
    localparam int MaxNameLen = 16;
    localparam int PoolBytes  = 4096;

    localparam int EW = $clog2(MaxEntries);     // entry address bits
    localparam int CW = $clog2(MaxNameLen);     // char position bits
    localparam int LW = $clog2(MaxNameLen + 1); // key length bits
    localparam int PW = $clog2(PoolBytes + 1);  // pool fill bits

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // One completed key with its operation
    typedef struct packed {
        logic                           op;
        logic [LW-1:0]                  len;
        logic [MaxNameLen-1:0][7:0]     chars;
        logic [15:0]                    value;
        logic                           kind;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_LEN_WAIT, S_LEN_CMP, S_CH_WAIT, S_CH_CMP, S_WRITE, S_DONE
    } t_bstate;

endpackage

// ----- rtl/symbol_table_insert_lookup.sv -----
// Top level of the symbol table: front end, job queue and table engine.
// Depends on stit_pkg, stit_front, stit_queue, stit_back.
//
//  channel | handshake          | payload
//  input   | i_valid / o_ready  | opcode, key_char, key_last, value, is_data
//  output  | o_valid / i_ready  | status, found_value, entry_index, entry_is_data
//
// Characters are taken one per cycle while the two-entry job queue has room.
// A completed key is checked, then each stored entry is scanned by a length read
// and compare, and each character of a stored name of equal length is read and
// compared; a hit skips the final scan step, an insert writes one character at a
// time after the scan, and an insert rejected as full goes straight to the result.
// The table is empty after reset; no clearing pass is needed.
// The engine holds its result until the output register is free.
module symbol_table_insert_lookup import stit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_key_char,
    input  logic        i_key_last,
    input  logic [15:0] i_value,
    input  logic        i_is_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_found_value,
    output logic [11:0] o_entry_index,
    output logic        o_entry_is_data
);
    logic q_full, q_empty, push, pop;
    t_job job_in, job_out;

    stit_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_q_full(q_full),
        .i_opcode, .i_key_char, .i_key_last, .i_value, .i_is_data,
        .o_ready, .o_push(push), .o_job(job_in)
    );

    stit_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(job_in), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_job(job_out)
    );

    stit_back u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_job(job_out), .o_pop(pop),
        .i_ready, .o_valid, .o_status, .o_found_value, .o_entry_index,
        .o_entry_is_data
    );
endmodule

// ----- rtl/stit_front.sv -----
// Front end: gathers key characters into a buffer and emits a job at key end.
// Depends on stit_pkg.
module stit_front import stit_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_q_full,
    input  logic       i_opcode,
    input  logic [7:0] i_key_char,
    input  logic       i_key_last,
    input  logic [15:0] i_value,
    input  logic       i_is_data,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);
    logic [LW-1:0]              r_len, n_len;
    logic [MaxNameLen-1:0][7:0] r_key, n_key;
    logic                       acc;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;

    // Append the character while the buffer has room
    always_comb begin
        n_key = r_key;
        n_len = r_len;
        if (r_len < LW'(MaxNameLen)) begin
            n_key[r_len[CW-1:0]] = i_key_char;
            n_len = r_len + LW'(1);
        end
    end

    assign o_push      = acc && i_key_last;
    assign o_job.op    = i_opcode;
    assign o_job.len   = n_len;
    assign o_job.chars = n_key;
    assign o_job.value = i_value;
    assign o_job.kind  = i_is_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (acc) begin
            r_len <= i_key_last ? '0 : n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_key <= n_key;
        end
    end
endmodule

// ----- rtl/stit_queue.sv -----
// Two-entry job queue between the front end and the table engine.
// Depends on stit_pkg.
module stit_queue import stit_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

// ----- rtl/stit_back.sv -----
// Table engine: scans stored names one character at a time, inserts, and
// registers the result. Depends on stit_pkg.
module stit_back import stit_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_found_value,
    output logic [11:0] o_entry_index,
    output logic        o_entry_is_data
);
    // Table storage
    logic [7:0]    name_mem [MaxEntries*MaxNameLen];
    logic [LW-1:0] len_mem  [MaxEntries];
    logic [15:0]   val_mem  [MaxEntries];
    logic          kind_mem [MaxEntries];

    t_bstate       r_state, n_state;
    t_job          r_job, n_job;
    logic [EW:0]   r_e, n_e, r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    logic [PW-1:0] r_pool, n_pool;
    logic [2:0]    r_st, n_st;
    logic [15:0]   r_rv, n_rv;
    logic [EW-1:0] r_ri, n_ri;
    logic          r_rk, n_rk;
    logic          r_ovalid;
    logic [LW-1:0] r_len_rd;
    logic [7:0]    r_ch_rd;
    logic [15:0]   r_val_rd;
    logic          r_kind_rd;

    logic          full, len_eq, ch_eq, last_ch, scan_end, out_free;
    logic [7:0]    key_ch;

    assign key_ch   = r_job.chars[r_i];
    assign full     = (r_count >= (EW+1)'(MaxEntries)) ||
                      ({1'b0, r_pool} + (PW+1)'(r_job.len) + (PW+1)'(1)
                       >= (PW+1)'(PoolBytes));
    assign len_eq   = (r_len_rd == r_job.len);
    assign ch_eq    = (r_ch_rd == key_ch);
    assign last_ch  = ({1'b0, r_i} == r_job.len - LW'(1));
    assign scan_end = (r_e == r_count);
    assign out_free = !r_ovalid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (!i_q_empty) n_state = S_CHECK;
            S_CHECK:    n_state = (r_job.op == OP_INSERT && full) ? S_DONE : S_LEN_WAIT;
            S_LEN_WAIT: begin
                if (scan_end) n_state = (r_job.op == OP_INSERT) ? S_WRITE : S_DONE;
                else          n_state = S_LEN_CMP;
            end
            S_LEN_CMP:  n_state = len_eq ? S_CH_WAIT : S_LEN_WAIT;
            S_CH_WAIT:  n_state = S_CH_CMP;
            S_CH_CMP: begin
                if (!ch_eq)       n_state = S_LEN_WAIT;
                else if (last_ch) n_state = S_DONE;
                else              n_state = S_CH_WAIT;
            end
            S_WRITE:    if (last_ch) n_state = S_DONE;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath updates per state
    always_comb begin
        n_job   = r_job;
        n_e     = r_e;
        n_i     = r_i;
        n_count = r_count;
        n_pool  = r_pool;
        n_st    = r_st;
        n_rv    = r_rv;
        n_ri    = r_ri;
        n_rk    = r_rk;
        o_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                end
            end
            S_CHECK: begin
                n_e  = '0;
                n_i  = '0;
                n_st = ST_FULL;
                n_rv = '0;
                n_ri = '0;
                n_rk = 1'b0;
            end
            S_LEN_WAIT: begin
                n_i = '0;
                if (scan_end) n_st = ST_NOT_FOUND;
            end
            S_LEN_CMP: begin
                n_i = '0;
                if (!len_eq) n_e = r_e + (EW+1)'(1);
            end
            S_CH_WAIT: ;
            S_CH_CMP: begin
                if (!ch_eq) begin
                    n_e = r_e + (EW+1)'(1);
                end else if (last_ch) begin
                    if (r_job.op == OP_INSERT) begin
                        n_st = ST_DUPLICATE;
                    end else begin
                        n_st = ST_FOUND;
                        n_rv = r_val_rd;
                        n_ri = r_e[EW-1:0];
                        n_rk = r_kind_rd;
                    end
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_WRITE: begin
                if (last_ch) begin
                    n_st    = ST_INSERTED;
                    n_rv    = r_job.value;
                    n_ri    = r_count[EW-1:0];
                    n_rk    = r_job.kind;
                    n_count = r_count + (EW+1)'(1);
                    n_pool  = r_pool + PW'(r_job.len) + PW'(1);
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pool   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pool  <= n_pool;
            if (r_state == S_DONE && out_free) r_ovalid <= 1'b1;
            else if (i_ready)                  r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_e   <= n_e;
        r_i   <= n_i;
        r_st  <= n_st;
        r_rv  <= n_rv;
        r_ri  <= n_ri;
        r_rk  <= n_rk;
        if (r_state == S_DONE && out_free) begin
            o_status        <= r_st;
            o_found_value   <= r_rv;
            o_entry_index   <= 12'(r_ri);
            o_entry_is_data <= r_rk;
        end
    end

    // Table memories: registered reads at the scan position
    always_ff @(posedge i_clk) begin
        r_len_rd  <= len_mem[r_e[EW-1:0]];
        r_val_rd  <= val_mem[r_e[EW-1:0]];
        r_kind_rd <= kind_mem[r_e[EW-1:0]];
        r_ch_rd   <= name_mem[{r_e[EW-1:0], r_i}];
        if (r_state == S_WRITE) begin
            name_mem[{r_count[EW-1:0], r_i}] <= key_ch;
            if (last_ch) begin
                len_mem[r_count[EW-1:0]]  <= r_job.len;
                val_mem[r_count[EW-1:0]]  <= r_job.value;
                kind_mem[r_count[EW-1:0]] <= r_job.kind;
            end
        end
    end

    assign o_valid = r_ovalid;
endmodule
